>>> rtl/core/nfba_pkg.sv
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared types and codes for the next-fit bitmap slot allocator.
// ----------------------------------------------------------------------------
package nfba_pkg;

	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	localparam logic [1:0] ST_ALLOCATED = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_RELEASED  = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	typedef struct packed {
		logic       req_type;
		logic [7:0] slot_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] granted_slot;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic scan;
	} cell_ctl_t;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

endpackage

>>> rtl/core/next_fit_bitmap_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// next_fit_bitmap_slot_allocator_unit
// Next-fit slot allocator built as a ring of one-bit slot cells.
// ----------------------------------------------------------------------------
// An allocate command loads a search token into the cell at the hint; the
// token then steps one cell per clock around the ring until it sits on a
// free slot, probing 1 to CAPACITY slots; busy is high while it scans and
// a full ring reports after CAPACITY probes. A release does not scan, and
// the next command may start right after it. Each command yields exactly one
// result, shown on result for the single cycle that done is high; there is
// no backpressure, so the receiver must take it in that cycle.
module next_fit_bitmap_slot_allocator_unit #(
	parameter int CAPACITY = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  nfba_pkg::cmd_t   cmd,
	output logic             done,
	output nfba_pkg::rsp_t   result
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

	nfba_pkg::state_t    state_q, state_d;
	nfba_pkg::cell_ctl_t ctl;
	nfba_pkg::rsp_t      rsp_q;
	logic                done_q;
	logic [IW-1:0]       hint_q;
	logic [IW-1:0]       pos_q;
	logic [IW-1:0]       cnt_q;
	logic [IW-1:0]       pos_next;
	logic [IW-1:0]       rel_idx;
	logic                accept;
	logic                do_alloc;
	logic                do_rel;
	logic                in_range;
	logic                hit;
	logic                scan_last;
	logic [CAPACITY-1:0] tok;
	logic [CAPACITY-1:0] claim;

	assign accept    = start & ~busy;
	assign do_alloc  = accept & (cmd.req_type == nfba_pkg::REQ_ALLOC);
	assign do_rel    = accept & (cmd.req_type == nfba_pkg::REQ_RELEASE);
	assign in_range  = (32'(cmd.slot_index) < CAPACITY);
	assign rel_idx   = IW'(cmd.slot_index);
	assign hit       = |claim;
	assign scan_last = (cnt_q == LAST);
	assign pos_next  = (pos_q == LAST) ? '0 : pos_q + 1'b1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [IW-1:0] IDX = IW'(i);
		nfba_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.start_here(hint_q == IDX),
			.rel_here  (do_rel & in_range & (rel_idx == IDX)),
			.tok_in    (tok[(i + CAPACITY - 1) % CAPACITY]),
			.tok_out   (tok[i]),
			.claim     (claim[i])
		);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nfba_pkg::S_IDLE: begin
				if (do_alloc) state_d = nfba_pkg::S_SCAN;
			end
			nfba_pkg::S_SCAN: begin
				if (hit || scan_last) state_d = nfba_pkg::S_IDLE;
			end
			default: state_d = nfba_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy     = (state_q == nfba_pkg::S_SCAN);
		ctl.load = do_alloc;
		ctl.scan = (state_q == nfba_pkg::S_SCAN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nfba_pkg::S_IDLE;
			done_q  <= 1'b0;
			hint_q  <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (state_q == nfba_pkg::S_SCAN) begin
				if (hit) begin
					done_q <= 1'b1;
					hint_q <= pos_next;
				end else if (scan_last) begin
					done_q <= 1'b1;
				end else begin
					pos_q <= pos_next;
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (do_alloc) begin
				pos_q <= hint_q;
				cnt_q <= '0;
			end else if (do_rel) begin
				done_q <= 1'b1;
				if (in_range && (rel_idx < hint_q)) hint_q <= rel_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == nfba_pkg::S_SCAN) begin
			if (hit) begin
				rsp_q.status       <= nfba_pkg::ST_ALLOCATED;
				rsp_q.granted_slot <= 6'(pos_q);
			end else begin
				rsp_q.status       <= nfba_pkg::ST_FULL;
				rsp_q.granted_slot <= '0;
			end
		end else if (do_rel) begin
			rsp_q.status       <= in_range ? nfba_pkg::ST_RELEASED : nfba_pkg::ST_RANGE;
			rsp_q.granted_slot <= '0;
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

`ifndef SYNTHESIS
	a_claim_onehot0: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(claim))
		else $error("more than one cell claimed");

	a_token_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nfba_pkg::S_SCAN) |-> $onehot(tok))
		else $error("search token lost or duplicated");

	a_hit_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nfba_pkg::S_SCAN && hit) |=>
		(done_q && rsp_q.status == nfba_pkg::ST_ALLOCATED))
		else $error("claim did not produce an allocation result");

	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy && done_q))
		else $error("result strobe while scanning");

	a_hint_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(hint_q) < CAPACITY)
		else $error("search hint out of range");
`endif

endmodule

>>> rtl/core/nfba_cell.sv
// ----------------------------------------------------------------------------
// nfba_cell
// One slot of the ring: used bit plus search token passed to the next cell.
// ----------------------------------------------------------------------------
module nfba_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  nfba_pkg::cell_ctl_t ctl,
	input  logic                start_here,
	input  logic                rel_here,
	input  logic                tok_in,
	output logic                tok_out,
	output logic                claim
);

	logic used_q;
	logic token_q;

	assign claim   = ctl.scan & token_q & ~used_q;
	assign tok_out = token_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			token_q <= 1'b0;
		end else begin
			if (rel_here) begin
				used_q <= 1'b0;
			end else if (claim) begin
				used_q <= 1'b1;
			end
			if (ctl.load) begin
				token_q <= start_here;
			end else if (ctl.scan) begin
				token_q <= tok_in;
			end
		end
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the next-fit bitmap slot allocator. A scoreboard
// class tracks the slot bitmap and search hint, predicts the reply to every
// accepted command and checks each done strobe against the oldest
// prediction. Stimulus is a directed opening followed by random phases that
// fill, drain, mix and flood the allocator, most with random gaps between commands.
// ----------------------------------------------------------------------------
module tb_top;
	import nfba_pkg::*;

	localparam int CAPACITY     = 64;
	localparam int RANDOM_ITEMS = 1250;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 4;

	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_BALANCED,
		MIX_NOISE
	} mix_t;

	class slot_ledger;
		bit [CAPACITY-1:0] used;
		int                hint;
		rsp_t              expected_replies[$];
		int                errors;

		function new();
			used = '0;
			hint = 0;
			errors = 0;
		endfunction

		function rsp_t apply_request(cmd_t c);
			rsp_t r;
			int   pos;
			r.status = ST_RANGE;
			r.granted_slot = '0;
			if (c.req_type == REQ_ALLOC) begin
				r.status = ST_FULL;
				pos = hint;
				for (int n = 0; n < CAPACITY && r.status == ST_FULL; n++) begin
					if (!used[pos]) begin
						used[pos] = 1'b1;
						r.status = ST_ALLOCATED;
						r.granted_slot = pos[5:0];
						hint = (pos + 1 >= CAPACITY) ? 0 : pos + 1;
					end else begin
						pos = (pos + 1) % CAPACITY;
					end
				end
			end else if (c.slot_index < CAPACITY) begin
				used[c.slot_index] = 1'b0;
				if (c.slot_index < hint)
					hint = c.slot_index;
				r.status = ST_RELEASED;
			end
			return r;
		endfunction

		function void note_request(cmd_t c);
			rsp_t r;
			r = apply_request(c);
			expected_replies = {expected_replies, r};
		endfunction

		function void check_reply(rsp_t got);
			rsp_t want;
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected result status=%0d slot=%0d",
					$time, got.status, got.granted_slot);
				errors++;
				return;
			end
			want = expected_replies.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d",
					$time, want.status, got.status);
				errors++;
			end
			if (got.granted_slot !== want.granted_slot) begin
				$display("%0t: granted_slot expected %0d actual %0d",
					$time, want.granted_slot, got.granted_slot);
				errors++;
			end
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	cmd_t cmd;
	rsp_t result;

	slot_ledger ledger = new();
	int         idle_cycles = 0;

	next_fit_bitmap_slot_allocator_unit #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				ledger.check_reply(result);
			if (start && !busy)
				ledger.note_request(cmd);
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("next_fit_bitmap_slot_allocator_unit regression: fail");
				$finish;
			end
		end
	end

	function automatic cmd_t make_cmd(logic kind, logic [7:0] idx);
		cmd_t c;
		c.req_type = kind;
		c.slot_index = idx;
		return c;
	endfunction

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic issue(cmd_t c);
		@(negedge clk);
		start = 1'b1;
		cmd = c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause_cycles(int n);
		if (n > 0) begin
			@(negedge clk);
			start = 1'b0;
			cmd = cmd_t'(9'($urandom));
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		pause_cycles(1);
		while (ledger.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		mix_t       mix;
		int         sent;
		int         len;
		int         pct;
		bit         steady;
		bit         first_phase;
		logic       kind;
		logic [7:0] idx;

		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed opening: hint moves, hint lowering, free and out-of-range releases
		issue(make_cmd(REQ_ALLOC, 8'h00));
		issue(make_cmd(REQ_ALLOC, 8'hFF));
		issue(make_cmd(REQ_ALLOC, 8'hAA));
		issue(make_cmd(REQ_RELEASE, 8'd1));
		issue(make_cmd(REQ_ALLOC, 8'h55));
		issue(make_cmd(REQ_RELEASE, 8'd63));
		issue(make_cmd(REQ_RELEASE, 8'd64));
		issue(make_cmd(REQ_RELEASE, 8'd255));
		issue(make_cmd(REQ_RELEASE, 8'd128));
		issue(make_cmd(REQ_RELEASE, 8'd0));
		issue(make_cmd(REQ_ALLOC, 8'h01));
		issue(make_cmd(REQ_ALLOC, 8'h80));
		issue(make_cmd(REQ_RELEASE, 8'd5));
		issue(make_cmd(REQ_RELEASE, 8'd0));
		issue(make_cmd(REQ_ALLOC, 8'h7F));
		issue(make_cmd(REQ_RELEASE, 8'd2));
		issue(make_cmd(REQ_ALLOC, 8'hFE));
		wait_drained();

		sent = 0;
		first_phase = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			mix = mix_t'($urandom_range(0, 3));
			len = $urandom_range(40, 150);
			steady = ($urandom_range(0, 3) == 0);
			if (first_phase) begin
				mix = MIX_FILL;
				len = 100;
			end
			for (int i = 0; i < len && sent < RANDOM_ITEMS; i++) begin
				pct = $urandom_range(0, 99);
				case (mix)
					MIX_FILL: kind = (pct < 92) ? REQ_ALLOC : REQ_RELEASE;
					MIX_DRAIN: kind = (pct < 80) ? REQ_RELEASE : REQ_ALLOC;
					MIX_BALANCED: kind = (pct < 50) ? REQ_RELEASE : REQ_ALLOC;
					default: kind = logic'($urandom_range(0, 1));
				endcase
				if (kind == REQ_RELEASE && mix != MIX_NOISE && $urandom_range(0, 9) != 0)
					idx = 8'($urandom_range(0, CAPACITY - 1));
				else
					idx = 8'($urandom_range(0, 255));
				issue(make_cmd(kind, idx));
				sent++;
				if (!steady && !first_phase)
					pause_cycles(random_gap());
			end
			first_phase = 1'b0;
			if ($urandom_range(0, 3) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.errors == 0 && ledger.pending() == 0) begin
			$display("next_fit_bitmap_slot_allocator_unit regression: pass");
		end else begin
			$display("next_fit_bitmap_slot_allocator_unit regression: fail");
		end
		$finish;
	end

endmodule
